>>> rtl/core/rhc_pkg.sv
// Shared constants for the RGB/HSL converter.
// No dependencies; used by the front end and the top level.
`timescale 1ns / 1ps

package rhc_pkg;

    // Conversion direction carried by the mode field
    localparam logic MODE_TO_HSL = 1'b0;
    localparam logic MODE_TO_RGB = 1'b1;

    // Stages in the front end, ahead of the divider chain
    localparam int FRONT_STAGES = 5;

endpackage

>>> rtl/core/rhc_if.sv
// Valid/ready channel interfaces for pixel words in and out.
// Depends on nothing; width follows the component width.
`timescale 1ns / 1ps

interface rhc_in_if #(parameter int W = 12);
    logic         valid;
    logic         ready;
    logic         mode;
    logic [W-1:0] red_or_hue;
    logic [W-1:0] green_or_sat;
    logic [W-1:0] blue_or_light;

    modport source (output valid, mode, red_or_hue, green_or_sat, blue_or_light,
                    input ready);
    modport sink   (input valid, mode, red_or_hue, green_or_sat, blue_or_light,
                    output ready);
endinterface

interface rhc_out_if #(parameter int W = 12);
    logic         valid;
    logic         ready;
    logic [W-1:0] hue_or_red;
    logic [W-1:0] sat_or_green;
    logic [W-1:0] light_or_blue;

    modport source (output valid, hue_or_red, sat_or_green, light_or_blue,
                    input ready);
    modport sink   (input valid, hue_or_red, sat_or_green, light_or_blue,
                    output ready);
endinterface

>>> rtl/core/rhc_front.sv
// Front end: min/max and dividend setup for rgb->hsl, full hsl->rgb math.
// Five registered stages with per-stage valid; uses rhc_pkg.
`timescale 1ns / 1ps

module rhc_front #(
    parameter int W = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    input  logic [W-1:0]      i_c,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_mode,
    output logic              o_zero,
    output logic [3*W-1:0]    o_res,
    output logic [2*W+2:0]    o_rem_h,
    output logic [W+2:0]      o_den_h,
    output logic [2*W-1:0]    o_rem_s,
    output logic [W:0]        o_den_s
);
    localparam int NS = rhc_pkg::FRONT_STAGES;
    localparam int M0 = 1 + W + (2*W+3) + (W+3) + 2*W + (W+1);
    localparam logic [W-1:0] ONE  = {W{1'b1}};
    localparam logic [W:0]   ONE1 = {1'b0, {W{1'b1}}};
    localparam logic [W:0]   TWO1 = {{W{1'b1}}, 1'b0};
    localparam logic [W:0]   FULL = {1'b1, {W{1'b0}}};

    logic [NS-1:0] r_v;
    logic [NS-1:0] r_mode;
    logic [NS:0]   rdy;

    // Stage registers
    logic [M0-1:0]  r1_m0, r2_m0, r3_m0, r4_m0;
    logic [W-1:0]   r1_t, r1_s, r1_l, r1_p;
    logic [2:0]     r1_sec, r2_sec, r3_sec, r4_sec;
    logic [2*W-1:0] r2_prod;
    logic [W-1:0]   r2_l, r2_p, r3_l, r4_l;
    logic [W-1:0]   r3_chroma, r4_chroma;
    logic [W:0]     r3_pm;
    logic [2*W:0]   r4_xprod;
    logic [M0-1:0]  r5_m0;
    logic [3*W-1:0] r5_res;

    // Stage 1 combinational terms
    logic [W-1:0]   mx, mn, d;
    logic [W:0]     sum, denom;
    logic [W+2:0]   d3, d6, r3v, g3v, b3v, n;
    logic [W:0]     dbl, tw;
    logic [W+2:0]   h3, six_h;
    logic [M0-1:0]  n1_m0;

    // Stage 3 terms
    logic [W-1:0]   q0;
    logic [W:0]     rr;
    logic [W-1:0]   n3_chroma;
    logic [W:0]     n3_pm;

    // Stage 5 terms
    logic [W-1:0]   x;
    logic [W-1:0]   cr, cg, cb;

    function automatic logic [W-1:0] comp_out(input logic [W-1:0] l,
                                              input logic [W-1:0] v,
                                              input logic [W-1:0] c);
        logic [W+2:0] sm;
        logic [W+1:0] half;
        sm   = {2'b00, l, 1'b0} + {2'b00, v, 1'b0} - {3'b000, c};
        half = sm[W+2:1];
        comp_out = (half > {2'b00, ONE}) ? ONE : half[W-1:0];
    endfunction

    // Ready ripples back through empty or draining stages
    always_comb begin
        rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[NS-1];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Advance mode bits alongside the valid bits
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_mode[0] <= i_mode;
        end
        for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
                r_mode[k] <= r_mode[k-1];
            end
        end
    end

    // Stage 1: extremes, dividends, mode-1 chroma factor and sector
    always_comb begin
        mx  = i_a;
        mn  = i_a;
        if (i_b > mx) mx = i_b;
        if (i_c > mx) mx = i_c;
        if (i_b < mn) mn = i_b;
        if (i_c < mn) mn = i_c;
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        denom = (sum <= ONE1) ? sum : (TWO1 - sum);
        d3  = {3'b000, d};
        d6  = (d3 << 2) + (d3 << 1);
        r3v = {3'b000, i_a};
        g3v = {3'b000, i_b};
        b3v = {3'b000, i_c};
        // Pick the sector offset by the largest channel, red first on ties
        if (mx == i_a) begin
            n = (i_b >= i_c) ? (g3v - b3v) : (d6 + g3v - b3v);
        end else if (mx == i_b) begin
            n = (d3 << 1) + b3v - r3v;
        end else begin
            n = (d3 << 2) + r3v - g3v;
        end
        n1_m0 = {(d == '0), sum[W:1], {n, {W{1'b0}}}, d6,
                 ({{W{1'b0}}, d} << W) - {{W{1'b0}}, d}, denom};

        dbl   = {i_c, 1'b0};
        tw    = (dbl >= ONE1) ? (dbl - ONE1) : (ONE1 - dbl);
        h3    = {3'b000, i_a};
        six_h = (h3 << 2) + (h3 << 1);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r1_m0     <= n1_m0;
            r1_t      <= W'(ONE1 - tw);
            r1_s      <= i_b;
            r1_l      <= i_c;
            r1_sec    <= six_h[W+2:W];
            r1_p      <= six_h[W-1:0];
        end
    end

    // Stage 2: chroma product
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r2_m0     <= r1_m0;
            r2_prod   <= {{W{1'b0}}, r1_t} * {{W{1'b0}}, r1_s};
            r2_l      <= r1_l;
            r2_p      <= r1_p;
            r2_sec    <= r1_sec;
        end
    end

    // Stage 3: divide by full scale with a fold and a two-step correction
    always_comb begin
        q0 = r2_prod[2*W-1:W];
        rr = {1'b0, r2_prod[W-1:0]} + {1'b0, q0};
        if (rr >= TWO1) begin
            n3_chroma = q0 + W'(2);
        end else if (rr >= ONE1) begin
            n3_chroma = q0 + W'(1);
        end else begin
            n3_chroma = q0;
        end
        n3_pm = r2_sec[0] ? (FULL - {1'b0, r2_p}) : {1'b0, r2_p};
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r3_m0     <= r2_m0;
            r3_chroma <= n3_chroma;
            r3_pm     <= n3_pm;
            r3_l      <= r2_l;
            r3_sec    <= r2_sec;
        end
    end

    // Stage 4: sector value product
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r4_m0     <= r3_m0;
            r4_xprod  <= {{(W+1){1'b0}}, r3_chroma} * {{W{1'b0}}, r3_pm};
            r4_chroma <= r3_chroma;
            r4_l      <= r3_l;
            r4_sec    <= r3_sec;
        end
    end

    // Stage 5: place chroma and x by sector, add the offset
    always_comb begin
        x = r4_xprod[2*W-1:W];
        case (r4_sec)
            3'd0: begin cr = r4_chroma; cg = x;         cb = '0;        end
            3'd1: begin cr = x;         cg = r4_chroma; cb = '0;        end
            3'd2: begin cr = '0;        cg = r4_chroma; cb = x;         end
            3'd3: begin cr = '0;        cg = x;         cb = r4_chroma; end
            3'd4: begin cr = x;         cg = '0;        cb = r4_chroma; end
            default: begin cr = r4_chroma; cg = '0;     cb = x;         end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r5_m0     <= r4_m0;
            r5_res    <= {comp_out(r4_l, cr, r4_chroma),
                          comp_out(r4_l, cg, r4_chroma),
                          comp_out(r4_l, cb, r4_chroma)};
        end
    end

    // Split the carried rgb->hsl fields
    assign o_mode  = r_mode[NS-1];
    assign o_zero  = r5_m0[M0-1];
    assign o_rem_h = r5_m0[M0-W-2 -: 2*W+3];
    assign o_den_h = r5_m0[M0-W-2-(2*W+3) -: W+3];
    assign o_rem_s = r5_m0[W+1 +: 2*W];
    assign o_den_s = r5_m0[W:0];
    assign o_res   = (r_mode[NS-1] == rhc_pkg::MODE_TO_HSL)
                   ? {{(2*W){1'b0}}, r5_m0[M0-2 -: W]} : r5_res;

`ifndef ASSERT_OFF
    // Hue offset stays below six times the spread for colored pixels
    a_hue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mode == rhc_pkg::MODE_TO_HSL && !o_zero)
        |-> (o_rem_h[2*W+2:W] < o_den_h))
        else $error("hue dividend out of range");
    // Saturation denominator is nonzero for colored pixels
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mode == rhc_pkg::MODE_TO_HSL && !o_zero)
        |-> (o_den_s != '0))
        else $error("zero saturation denominator");
    // A stalled front end word keeps its mode and result
    a_mode_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_mode) && $stable(o_res)))
        else $error("front end word changed under stall");
`endif

endmodule

>>> rtl/core/rhc_div_stage.sv
// One quotient bit of the hue and saturation dividers, registered.
// Depends on nothing; chained by the top level, one stage per bit.
`timescale 1ns / 1ps

module rhc_div_stage #(
    parameter int W    = 12,
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic              i_zero,
    input  logic [3*W-1:0]    i_res,
    input  logic [2*W+2:0]    i_rem_h,
    input  logic [W+2:0]      i_den_h,
    input  logic [W-1:0]      i_q_h,
    input  logic [2*W-1:0]    i_rem_s,
    input  logic [W:0]        i_den_s,
    input  logic [W-1:0]      i_q_s,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_mode,
    output logic              o_zero,
    output logic [3*W-1:0]    o_res,
    output logic [2*W+2:0]    o_rem_h,
    output logic [W+2:0]      o_den_h,
    output logic [W-1:0]      o_q_h,
    output logic [2*W-1:0]    o_rem_s,
    output logic [W:0]        o_den_s,
    output logic [W-1:0]      o_q_s
);
    localparam logic [W-1:0] BIT = W'(1) << STEP;

    logic           r_v;
    logic           r_mode, r_zero;
    logic [3*W-1:0] r_res;
    logic [2*W+2:0] r_rem_h;
    logic [W+2:0]   r_den_h;
    logic [W-1:0]   r_q_h;
    logic [2*W-1:0] r_rem_s;
    logic [W:0]     r_den_s;
    logic [W-1:0]   r_q_s;

    logic [2*W+2:0] sh_h;
    logic [2*W-1:0] sh_s;
    logic           ge_h, ge_s;

    // Trial subtract of the shifted divisors
    assign sh_h = {{W{1'b0}}, i_den_h} << STEP;
    assign sh_s = {{(W-1){1'b0}}, i_den_s} << STEP;
    assign ge_h = (i_rem_h >= sh_h);
    assign ge_s = (i_rem_s >= sh_s);

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // Advance payload with the new quotient bits
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_mode  <= i_mode;
            r_zero  <= i_zero;
            r_res   <= i_res;
            r_den_h <= i_den_h;
            r_den_s <= i_den_s;
            r_rem_h <= ge_h ? (i_rem_h - sh_h) : i_rem_h;
            r_rem_s <= ge_s ? (i_rem_s - sh_s) : i_rem_s;
            r_q_h   <= ge_h ? (i_q_h | BIT) : i_q_h;
            r_q_s   <= ge_s ? (i_q_s | BIT) : i_q_s;
        end
    end

    assign o_valid = r_v;
    assign o_mode  = r_mode;
    assign o_zero  = r_zero;
    assign o_res   = r_res;
    assign o_rem_h = r_rem_h;
    assign o_den_h = r_den_h;
    assign o_q_h   = r_q_h;
    assign o_rem_s = r_rem_s;
    assign o_den_s = r_den_s;
    assign o_q_s   = r_q_s;

endmodule

>>> rtl/core/rgb_hsl_color_converter.sv
// Channel      Dir  Fields                                    Handshake
// i_pix        in   mode, red_or_hue, green_or_sat, blue_or_light  valid/ready
// o_pix        out  hue_or_red, sat_or_green, light_or_blue        valid/ready
//
// One word per clock sustained while o_pix is not stalled; the depth is
// five front end stages plus one divider stage per quotient bit.
// The hue and saturation dividers set the depth: one restoring step each stage.
// i_rst_n is synchronous and clears only the valid bits.
// Each stage holds under stall and refills as soon as its successor moves.
// Top level: rhc_front followed by the rhc_div_stage chain; uses rhc_pkg, rhc_if.
`timescale 1ns / 1ps

module rgb_hsl_color_converter #(
    parameter int COMPONENT_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rhc_in_if.sink               i_pix,
    rhc_out_if.source            o_pix
);
    localparam int W = COMPONENT_BITS;

    logic           v     [0:W];
    logic           rdy   [0:W];
    logic           mode  [0:W];
    logic           zero  [0:W];
    logic [3*W-1:0] res   [0:W];
    logic [2*W+2:0] rem_h [0:W];
    logic [W+2:0]   den_h [0:W];
    logic [W-1:0]   q_h   [0:W];
    logic [2*W-1:0] rem_s [0:W];
    logic [W:0]     den_s [0:W];
    logic [W-1:0]   q_s   [0:W];

    // Front end
    rhc_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_mode  (i_pix.mode),
        .i_a     (i_pix.red_or_hue),
        .i_b     (i_pix.green_or_sat),
        .i_c     (i_pix.blue_or_light),
        .o_valid (v[0]),
        .i_ready (rdy[0]),
        .o_mode  (mode[0]),
        .o_zero  (zero[0]),
        .o_res   (res[0]),
        .o_rem_h (rem_h[0]),
        .o_den_h (den_h[0]),
        .o_rem_s (rem_s[0]),
        .o_den_s (den_s[0])
    );

    assign q_h[0] = '0;
    assign q_s[0] = '0;

    // Divider chain, most significant quotient bit first
    for (genvar j = 0; j < W; j++) begin : g_div
        rhc_div_stage #(.W(W), .STEP(W - 1 - j)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[j]),
            .o_ready (rdy[j]),
            .i_mode  (mode[j]),
            .i_zero  (zero[j]),
            .i_res   (res[j]),
            .i_rem_h (rem_h[j]),
            .i_den_h (den_h[j]),
            .i_q_h   (q_h[j]),
            .i_rem_s (rem_s[j]),
            .i_den_s (den_s[j]),
            .i_q_s   (q_s[j]),
            .o_valid (v[j+1]),
            .i_ready (rdy[j+1]),
            .o_mode  (mode[j+1]),
            .o_zero  (zero[j+1]),
            .o_res   (res[j+1]),
            .o_rem_h (rem_h[j+1]),
            .o_den_h (den_h[j+1]),
            .o_q_h   (q_h[j+1]),
            .o_rem_s (rem_s[j+1]),
            .o_den_s (den_s[j+1]),
            .o_q_s   (q_s[j+1])
        );
    end

    // Select the result word by direction; grey pixels give no hue or saturation
    assign rdy[W]      = o_pix.ready;
    assign o_pix.valid = v[W];
    always_comb begin
        if (mode[W] == rhc_pkg::MODE_TO_HSL) begin
            o_pix.hue_or_red   = zero[W] ? '0 : q_h[W];
            o_pix.sat_or_green = zero[W] ? '0 : q_s[W];
        end else begin
            o_pix.hue_or_red   = res[W][3*W-1:2*W];
            o_pix.sat_or_green = res[W][2*W-1:W];
        end
        o_pix.light_or_blue = res[W][W-1:0];
    end

`ifndef ASSERT_OFF
    // An empty output stage means the whole pipe can take a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !v[W] |-> i_pix.ready)
        else $error("input stalled with empty output stage");
    // Final hue remainder is below its divisor
    a_hue_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v[W] && mode[W] == rhc_pkg::MODE_TO_HSL && !zero[W])
        |-> (rem_h[W] < {{W{1'b0}}, den_h[W]}))
        else $error("hue division left a full divisor");
    // Final saturation remainder is below its divisor
    a_sat_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v[W] && mode[W] == rhc_pkg::MODE_TO_HSL && !zero[W])
        |-> (rem_s[W] < {{(W-1){1'b0}}, den_s[W]}))
        else $error("saturation division left a full divisor");
`endif

endmodule
